### rtl/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

  // Display geometry defaults
  localparam int COLUMNS_DEF = 16;
  localparam int ROWS_DEF    = 2;

  // Request codes on the action field
  localparam logic [2:0] ACT_PUT_CHAR = 3'd0;
  localparam logic [2:0] ACT_GOTO     = 3'd1;
  localparam logic [2:0] ACT_NEWLINE  = 3'd2;
  localparam logic [2:0] ACT_CLEAR    = 3'd3;
  localparam logic [2:0] ACT_INIT     = 3'd4;
  localparam logic [2:0] ACT_STYLE    = 3'd5;

  // Control characters
  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  // Cursor style codes
  localparam logic [1:0] STYLE_OFF   = 2'd0;
  localparam logic [1:0] STYLE_ON    = 2'd1;
  localparam logic [1:0] STYLE_BLINK = 2'd2;

  // Display commands
  localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ADDR_ROW0  = 8'h80;
  localparam logic [7:0] CMD_ADDR_ROW1  = 8'hC0;
  localparam logic [7:0] CMD_CURS_OFF   = 8'h0C;
  localparam logic [7:0] CMD_CURS_ON    = 8'h0E;
  localparam logic [7:0] CMD_CURS_BLINK = 8'h0F;

  // Register select
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Config register reset value
  localparam logic [3:0] INIT_CTRL_RST = 4'd14;

  // Init sequence step of the display-control write, and last step
  localparam logic [2:0] INIT_STEP_CTRL = 3'd3;
  localparam logic [2:0] INIT_STEP_LAST = 3'd5;

  // Queue between front and back
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_CR,
    OP_LF,
    OP_GOTO,
    OP_NEWLINE,
    OP_CLEAR,
    OP_INIT,
    OP_STYLE
  } clt_op_e;

  typedef struct packed {
    clt_op_e     kind;
    logic [7:0]  data;    // character or cursor command byte
    logic [3:0]  column;  // raw goto column
    logic        row;     // raw goto row
  } clt_op_t;

  // Fixed part of the init sequence; the control step is patched in the back end
  function automatic logic [7:0] init_byte(input logic [2:0] step);
    logic [7:0] b;
    case (step)
      3'd0, 3'd1, 3'd2: b = CMD_FUNC_SET;
      3'd4:             b = CMD_ENTRY_MODE;
      3'd5:             b = CMD_CLEAR;
      default:          b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/clt_front.sv
`timescale 1ns / 1ps

module clt_front (
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [2:0]       action_i,
  input  logic [7:0]       char_code_i,
  input  logic [3:0]       column_i,
  input  logic             row_i,
  input  logic [1:0]       cursor_style_i,
  output logic             push_o,
  output clt_pkg::clt_op_t op_o
);

  logic has_write;

  always_comb begin
    has_write   = 1'b1;
    op_o.kind   = clt_pkg::OP_CHAR;
    op_o.data   = char_code_i;
    op_o.column = column_i;
    op_o.row    = row_i;
    unique case (action_i)
      clt_pkg::ACT_PUT_CHAR: begin
        if (char_code_i == clt_pkg::CHAR_CR) begin
          op_o.kind = clt_pkg::OP_CR;
        end else if (char_code_i == clt_pkg::CHAR_LF) begin
          op_o.kind = clt_pkg::OP_LF;
        end else begin
          op_o.kind = clt_pkg::OP_CHAR;
        end
      end
      clt_pkg::ACT_GOTO:    op_o.kind = clt_pkg::OP_GOTO;
      clt_pkg::ACT_NEWLINE: op_o.kind = clt_pkg::OP_NEWLINE;
      clt_pkg::ACT_CLEAR:   op_o.kind = clt_pkg::OP_CLEAR;
      clt_pkg::ACT_INIT:    op_o.kind = clt_pkg::OP_INIT;
      clt_pkg::ACT_STYLE: begin
        op_o.kind = clt_pkg::OP_STYLE;
        unique case (cursor_style_i)
          clt_pkg::STYLE_OFF:   op_o.data = clt_pkg::CMD_CURS_OFF;
          clt_pkg::STYLE_ON:    op_o.data = clt_pkg::CMD_CURS_ON;
          clt_pkg::STYLE_BLINK: op_o.data = clt_pkg::CMD_CURS_BLINK;
          default:              has_write = 1'b0;
        endcase
      end
      default: has_write = 1'b0;  // unused codes are swallowed
    endcase
  end

  assign push_o = in_valid_i & ~in_stall_i & has_write;

endmodule

### rtl/clt_queue.sv
`timescale 1ns / 1ps

module clt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  clt_pkg::clt_op_t push_op_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             head_valid_o,
  output clt_pkg::clt_op_t head_op_o
);

  localparam int IDX_W = (clt_pkg::QDEPTH > 1) ? $clog2(clt_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(clt_pkg::QDEPTH + 1);

  clt_pkg::clt_op_t       mem_q [clt_pkg::QDEPTH];
  logic [IDX_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [IDX_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o       = (cnt_q == CNT_W'(clt_pkg::QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_op_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(clt_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  property p_no_overfill;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(clt_pkg::QDEPTH);
  endproperty
  a_no_overfill: assert property (p_no_overfill) else $error("queue count overflow");

endmodule

### rtl/clt_back.sv
`timescale 1ns / 1ps

module clt_back #(
  parameter int COLUMNS = clt_pkg::COLUMNS_DEF,
  parameter int ROWS    = clt_pkg::ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  clt_pkg::clt_op_t head_op_i,
  output logic             pop_o,
  input  logic [3:0]       init_ctrl_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic             register_select_o,
  output logic [7:0]       bus_byte_o,
  output logic             last_write_o
);

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  logic [COL_W-1:0] col_q, col_d, goto_col;
  logic             row_q, row_d, goto_row;
  logic [2:0]       step_q;
  logic             emit;
  logic             wr_rs, wr_last;
  logic [7:0]       wr_byte;
  logic             out_valid_q;
  logic             out_rs_q, out_last_q;
  logic [7:0]       out_byte_q;

  function automatic logic adv_row(input logic r);
    return (ROWS > 1) ? ~r : 1'b0;
  endfunction

  function automatic logic [7:0] addr_cmd(input logic r, input logic [COL_W-1:0] c);
    logic [7:0] base;
    base = r ? clt_pkg::CMD_ADDR_ROW1 : clt_pkg::CMD_ADDR_ROW0;
    return base + 8'(c);
  endfunction

  // Goto target, saturated to the display geometry
  always_comb begin
    if (32'(head_op_i.column) >= COLUMNS) begin
      goto_col = LAST_COL;
    end else begin
      goto_col = COL_W'(head_op_i.column);
    end
    goto_row = (ROWS > 1) ? head_op_i.row : 1'b0;
  end

  assign emit = head_valid_i & (~out_valid_q | ~out_stall_i);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    wr_rs   = clt_pkg::RS_CMD;
    wr_byte = 8'h00;
    wr_last = 1'b1;
    case (head_op_i.kind)
      clt_pkg::OP_CHAR: begin
        if (step_q == 3'd0) begin
          wr_rs   = clt_pkg::RS_DATA;
          wr_byte = head_op_i.data;
          if (col_q == LAST_COL) begin
            col_d   = '0;
            row_d   = adv_row(row_q);
            wr_last = 1'b0;
          end else begin
            col_d = col_q + 1'b1;
          end
        end else begin
          wr_byte = addr_cmd(row_q, col_q);  // position already wrapped
        end
      end
      clt_pkg::OP_CR: begin
        row_d   = adv_row(row_q);
        wr_byte = addr_cmd(row_d, col_q);
      end
      clt_pkg::OP_LF: begin
        col_d   = '0;
        wr_byte = addr_cmd(row_q, '0);
      end
      clt_pkg::OP_GOTO: begin
        col_d   = goto_col;
        row_d   = goto_row;
        wr_byte = addr_cmd(goto_row, goto_col);
      end
      clt_pkg::OP_NEWLINE: begin
        col_d   = '0;
        row_d   = adv_row(row_q);
        wr_byte = addr_cmd(row_d, '0);
      end
      clt_pkg::OP_CLEAR: begin
        col_d = '0;
        row_d = 1'b0;
        if (step_q == 3'd0) begin
          wr_byte = clt_pkg::CMD_CLEAR;
          wr_last = 1'b0;
        end else begin
          wr_byte = clt_pkg::CMD_ADDR_ROW0;
        end
      end
      clt_pkg::OP_INIT: begin
        col_d   = '0;
        row_d   = 1'b0;
        wr_last = (step_q == clt_pkg::INIT_STEP_LAST);
        if (step_q == clt_pkg::INIT_STEP_CTRL) begin
          wr_byte = {4'h0, init_ctrl_i};
        end else begin
          wr_byte = clt_pkg::init_byte(step_q);
        end
      end
      default: begin  // cursor style
        wr_byte = head_op_i.data;
      end
    endcase
  end

  assign pop_o = emit & wr_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        col_q       <= col_d;
        row_q       <= row_d;
        step_q      <= wr_last ? 3'd0 : step_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_rs_q   <= wr_rs;
      out_byte_q <= wr_byte;
      out_last_q <= wr_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign register_select_o = out_rs_q;
  assign bus_byte_o        = out_byte_q;
  assign last_write_o      = out_last_q;

  property p_col_range;
    @(posedge clk_i) disable iff (!rst_ni) 32'(col_q) < COLUMNS;
  endproperty
  a_col_range: assert property (p_col_range) else $error("column out of range");

  property p_step_range;
    @(posedge clk_i) disable iff (!rst_ni) step_q <= clt_pkg::INIT_STEP_LAST;
  endproperty
  a_step_range: assert property (p_step_range) else $error("sequence step overrun");

  property p_mid_seq_head;
    @(posedge clk_i) disable iff (!rst_ni) (step_q != 3'd0) |-> head_valid_i;
  endproperty
  a_mid_seq_head: assert property (p_mid_seq_head) else $error("request lost mid-burst");

  property p_pop_last;
    @(posedge clk_i) disable iff (!rst_ni) pop_o |=> (out_valid_q && out_last_q);
  endproperty
  a_pop_last: assert property (p_pop_last) else $error("request retired without last write");

endmodule

### rtl/char_lcd_cursor_tracker.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+----------------------------------------
// in       | input     | in_valid_i / in_stall_o | action, char_code, column, row, style
// out      | output    | out_valid_o/out_stall_i | register_select, bus_byte, last_write
// cfg      | input     | cfg_valid_i/cfg_ready_o | init_display_control (4 bits)
//
// Each item causes as many bus writes as its sequence needs: one for characters and cursor
// moves, two for a wrapping character or clear, six for init. The write sequencer sets
// the rate, and starts an item only after the last write of the item before it.
// Items arrive through a two-entry queue; in_stall_o rises only when it is full.
// Reset is asynchronous and clears position (0,0), the queue and the output slot.
// A stalled output keeps its write; the queue keeps taking items meanwhile.
module char_lcd_cursor_tracker #(
  parameter int COLUMNS = clt_pkg::COLUMNS_DEF,
  parameter int ROWS    = clt_pkg::ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [7:0] char_code_i,
  input  logic [3:0] column_i,
  input  logic       row_i,
  input  logic [1:0] cursor_style_i,
  // bus write channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       register_select_o,
  output logic [7:0] bus_byte_o,
  output logic       last_write_o,
  // config channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  clt_pkg::clt_op_t push_op, head_op;
  logic             push, pop, full, head_valid;
  logic [3:0]       init_ctrl_q;

  // Display-control value used in the init burst; the user must write it only when idle (not enforced here)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_ctrl_q <= clt_pkg::INIT_CTRL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      init_ctrl_q <= cfg_data_i;
    end
  end

  // Stall from the registered queue fill only
  assign in_stall_o = full;

  // Front: decode the request; items that cause no write are dropped here
  clt_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .action_i       (action_i),
    .char_code_i    (char_code_i),
    .column_i       (column_i),
    .row_i          (row_i),
    .cursor_style_i (cursor_style_i),
    .push_o         (push),
    .op_o           (push_op)
  );

  clt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_op_i    (push_op),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_op_o    (head_op)
  );

  // Back: cursor tracking and write sequencing into the output register
  clt_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (head_valid),
    .head_op_i         (head_op),
    .pop_o             (pop),
    .init_ctrl_i       (init_ctrl_q),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .register_select_o (register_select_o),
    .bus_byte_o        (bus_byte_o),
    .last_write_o      (last_write_o)
  );

endmodule
